>>> design/cdmc_pkg.sv
// Shared types, calendar constants and month tables for the day-to-month-count core.
package cdmc_pkg;

  typedef enum logic [1:0] {
    CAL_GREG = 2'd0,
    CAL_365  = 2'd1,
    CAL_360  = 2'd2
  } cal_e;

  typedef struct packed {
    logic valid;
    cal_e kind;
  } side_t;

  localparam int unsigned DOE_W   = 18;
  localparam int unsigned MONTH_W = 18;
  localparam int unsigned OUT_TW  = 24;
  localparam int unsigned YOE_W   = 9;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned REM_W   = 9;
  localparam int unsigned MON_W   = 4;

  localparam int unsigned ERA_DAYS     = 146097;
  localparam int unsigned JAN_FEB_DAYS = 60;
  localparam int unsigned Z_OFFS       = ERA_DAYS - JAN_FEB_DAYS;
  localparam int unsigned DAYS_NOLEAP  = 365;
  localparam int unsigned DAYS_FIXED   = 360;
  localparam int unsigned DAYS_MONTH30 = 30;
  localparam int unsigned DAYS_4Y      = 1460;
  localparam int unsigned DAYS_100Y    = 36524;
  localparam int unsigned YEARS_ERA    = 400;
  localparam int unsigned YEARS_100    = 100;
  localparam int unsigned MONTHS       = 12;
  localparam int unsigned MP_JAN       = 10;  // March-based index of January
  localparam int unsigned MAR_MON      = 2;

  // Round-up reciprocals, exact for the operand ranges used
  localparam int unsigned S_4Y   = 29;
  localparam int unsigned M_4Y_W = 19;
  localparam logic [M_4Y_W-1:0] M_4Y =
    M_4Y_W'(((64'd1 << S_4Y) + DAYS_4Y - 1) / DAYS_4Y);

  localparam int unsigned S_365   = 27;
  localparam int unsigned M_365_W = 19;
  localparam logic [M_365_W-1:0] M_365 =
    M_365_W'(((64'd1 << S_365) + DAYS_NOLEAP - 1) / DAYS_NOLEAP);

  localparam int unsigned MP_NUM_W = 11;
  localparam int unsigned S_153    = 19;
  localparam int unsigned M_153_W  = 12;
  localparam logic [M_153_W-1:0] M_153 =
    M_153_W'(((64'd1 << S_153) + 153 - 1) / 153);

  localparam logic [REM_W-1:0] NOLEAP_START [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  function automatic cal_e decode_mode(logic [1:0] code);
    case (code)
      CAL_365: return CAL_365;
      CAL_360: return CAL_360;
      default: return CAL_GREG;
    endcase
  endfunction

  function automatic logic [MON_W-1:0] mon_noleap(logic [REM_W-1:0] rem);
    logic [MON_W-1:0] m;
    m = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (rem >= NOLEAP_START[i]) m = m + MON_W'(1);
    end
    return m;
  endfunction

  function automatic logic [MON_W-1:0] mon_fixed(logic [REM_W-1:0] rem);
    logic [MON_W-1:0] m;
    m = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (rem >= REM_W'(DAYS_MONTH30 * i)) m = m + MON_W'(1);
    end
    return m;
  endfunction

endpackage

>>> design/cdmc_div.sv
// Two-stage divider by a calendar constant (era, 365 or 360 days) via reciprocal.
module cdmc_div #(
  parameter int unsigned XW = 23
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  cdmc_pkg::side_t              side_i,
  input  logic [XW-1:0]                x_i,
  output cdmc_pkg::side_t              side_o,
  output logic [XW-9:0]                q_o,
  output logic [cdmc_pkg::DOE_W-1:0]   r_o
);

  localparam int unsigned QW = XW - 8;
  localparam int unsigned MW = XW - 8;
  localparam int unsigned CW = cdmc_pkg::DOE_W;

  // floor reciprocals: estimate is exact or one low
  localparam logic [MW-1:0] M_ERA = MW'((64'd1 << XW) / cdmc_pkg::ERA_DAYS);
  localparam logic [MW-1:0] M_NL  = MW'((64'd1 << XW) / cdmc_pkg::DAYS_NOLEAP);
  localparam logic [MW-1:0] M_FX  = MW'((64'd1 << XW) / cdmc_pkg::DAYS_FIXED);

  cdmc_pkg::side_t   side2_q;
  logic [QW-1:0]     qe_q, qe_d;
  logic [XW-1:0]     x2_q;
  logic [MW-1:0]     m_sel;
  logic [XW+MW-1:0]  prod;

  logic [CW-1:0]     c_sel;
  logic [XW-1:0]     qc, rem;
  logic              bump;
  logic [QW-1:0]     q_d;
  logic [CW-1:0]     r_d;

  always_comb begin
    case (side_i.kind)
      cdmc_pkg::CAL_365: m_sel = M_NL;
      cdmc_pkg::CAL_360: m_sel = M_FX;
      default:           m_sel = M_ERA;
    endcase
    prod = (XW+MW)'(x_i) * (XW+MW)'(m_sel);
    qe_d = prod[XW+QW-1:XW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side2_q <= '0;
    end else if (en_i) begin
      side2_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe_q <= qe_d;
      x2_q <= x_i;
    end
  end

  always_comb begin
    case (side2_q.kind)
      cdmc_pkg::CAL_365: c_sel = CW'(cdmc_pkg::DAYS_NOLEAP);
      cdmc_pkg::CAL_360: c_sel = CW'(cdmc_pkg::DAYS_FIXED);
      default:           c_sel = CW'(cdmc_pkg::ERA_DAYS);
    endcase
    qc   = XW'(XW'(qe_q) * XW'(c_sel));
    rem  = x2_q - qc;
    bump = (rem >= XW'(c_sel));
    q_d  = bump ? qe_q + QW'(1) : qe_q;
    r_d  = bump ? CW'(rem - XW'(c_sel)) : CW'(rem);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_o <= '0;
    end else if (en_i) begin
      side_o <= side2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= q_d;
      r_o <= r_d;
    end
  end

endmodule

>>> design/calendar_days_to_month_count_core.sv
// Pipelined day count to month count converter, top level.
//
// Usage: day counts enter on the s_axis stream, one word per item; month counts
// (12 * year + zero-based month) leave on the m_axis stream in the same order.
// The calendar is picked by cfg_wdata_i when cfg_we_i is high: 0 Gregorian,
// 1 fixed 365-day, 2 fixed 360-day, 3 behaves as Gregorian. Write it only
// while the pipeline is empty.
// Pipeline: eight register stages (entry, two divider stages, four
// Gregorian year/day stages, output register).
// Throughput: one word per cycle while the output is not stalled; the chain
// of reciprocal multipliers sets the depth.
// Stall: all stages advance together; s_axis_tready drops only while a
// result waits in the output register and m_axis_tready is low. Nothing is
// lost or repeated.
// Reset: pipeline emptied, calendar returns to Gregorian.
module calendar_days_to_month_count_core #(
  parameter int unsigned DAY_BITS = 22
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i,    // calendar_mode
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((DAY_BITS+7)/8)*8-1:0]     s_axis_tdata,   // day_count
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cdmc_pkg::OUT_TW-1:0]       m_axis_tdata    // month_count
);

  localparam longint unsigned DAY_SPAN = 64'd1 << DAY_BITS;
  localparam int unsigned ZW    = $clog2(DAY_SPAN + cdmc_pkg::Z_OFFS);
  localparam int unsigned QW    = ZW - 8;
  localparam int unsigned DW    = cdmc_pkg::DOE_W;
  localparam int unsigned MW18  = cdmc_pkg::MONTH_W;
  localparam int unsigned A_W   = 7;
  localparam int unsigned P4_W  = DW + cdmc_pkg::M_4Y_W;
  localparam int unsigned P365_W = DW + cdmc_pkg::M_365_W;
  localparam int unsigned P153_W = cdmc_pkg::MP_NUM_W + cdmc_pkg::M_153_W;

  cdmc_pkg::cal_e  mode_q;
  logic            en;

  // stage 1
  cdmc_pkg::side_t s1_q, s1_d;
  logic [ZW-1:0]   x1_q, x1_d;
  logic [DAY_BITS-1:0] day;

  // stage 3 (divider outputs)
  cdmc_pkg::side_t s3;
  logic [QW-1:0]   q3;
  logic [DW-1:0]   r3;

  // stage 4
  cdmc_pkg::side_t      s4_q;
  logic [DW-1:0]        t4_q, t4_d, doe4_q;
  logic [QW-1:0]        yb4_q, yb4_d;
  logic [cdmc_pkg::MON_W-1:0] mng4_q, mng4_d;
  logic [P4_W-1:0]      a_prod;
  logic [A_W-1:0]       a4;
  logic [1:0]           c4;

  // stage 5
  cdmc_pkg::side_t      s5_q;
  logic [DW-1:0]        doe5_q;
  logic [cdmc_pkg::YOE_W-1:0] yoe5_q, yoe5_d;
  logic [QW-1:0]        yb5_q;
  logic [cdmc_pkg::MON_W-1:0] mng5_q;
  logic [P365_W-1:0]    y_prod;

  // stage 6
  cdmc_pkg::side_t      s6_q;
  logic [cdmc_pkg::DOY_W-1:0] doy6_q, doy6_d;
  logic [cdmc_pkg::YOE_W-1:0] yoe6_q;
  logic [QW-1:0]        yb6_q;
  logic [cdmc_pkg::MON_W-1:0] mng6_q;
  logic [1:0]           c100;

  // stage 7
  cdmc_pkg::side_t      s7_q;
  logic [cdmc_pkg::MON_W-1:0] mon7_q, mon7_d;
  logic                 yinc7_q, yinc7_d;
  logic [cdmc_pkg::YOE_W-1:0] yoe7_q;
  logic [QW-1:0]        yb7_q;
  logic [cdmc_pkg::MP_NUM_W-1:0] mp_num;
  logic [P153_W-1:0]    mp_prod;
  logic [cdmc_pkg::MON_W-1:0] mp;

  // stage 8 (output)
  logic                 v8_q;
  logic [MW18-1:0]      out_q, out_d, yr8;

  assign en            = !v8_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cdmc_pkg::CAL_GREG;
    end else if (cfg_we_i) begin
      mode_q <= cdmc_pkg::decode_mode(cfg_wdata_i);
    end
  end

  // stage 1: shift Gregorian days to March-based, one era ahead
  always_comb begin
    day        = s_axis_tdata[DAY_BITS-1:0];
    s1_d.valid = s_axis_tvalid;
    s1_d.kind  = mode_q;
    x1_d       = (mode_q == cdmc_pkg::CAL_GREG) ? ZW'(day) + ZW'(cdmc_pkg::Z_OFFS)
                                                : ZW'(day);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) x1_q <= x1_d;
  end

  // stages 2-3: era/day-of-era or year/day-of-year
  cdmc_div #(
    .XW(ZW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (s1_q),
    .x_i    (x1_q),
    .side_o (s3),
    .q_o    (q3),
    .r_o    (r3)
  );

  // stage 4: doe - doe/1460 + doe/36524 - doe/146096
  always_comb begin
    a_prod = P4_W'(r3) * P4_W'(cdmc_pkg::M_4Y);
    a4     = a_prod[cdmc_pkg::S_4Y+A_W-1:cdmc_pkg::S_4Y];
    c4     = '0;
    for (int k = 1; k < 4; k++) begin
      if (r3 >= DW'(cdmc_pkg::DAYS_100Y * k)) c4 = c4 + 2'd1;
    end
    t4_d  = r3 - DW'(a4) + DW'(c4);
    yb4_d = (s3.kind == cdmc_pkg::CAL_GREG) ? QW'(q3 * QW'(cdmc_pkg::YEARS_ERA)) : q3;
    case (s3.kind)
      cdmc_pkg::CAL_365: mng4_d = cdmc_pkg::mon_noleap(r3[cdmc_pkg::REM_W-1:0]);
      cdmc_pkg::CAL_360: mng4_d = cdmc_pkg::mon_fixed(r3[cdmc_pkg::REM_W-1:0]);
      default:           mng4_d = '0;
    endcase
  end

  // stage 5: year of era
  always_comb begin
    y_prod = P365_W'(t4_q) * P365_W'(cdmc_pkg::M_365);
    yoe5_d = y_prod[cdmc_pkg::S_365+cdmc_pkg::YOE_W-1:cdmc_pkg::S_365];
  end

  // stage 6: day of March-based year
  always_comb begin
    c100 = '0;
    for (int k = 1; k < 4; k++) begin
      if (yoe5_q >= cdmc_pkg::YOE_W'(cdmc_pkg::YEARS_100 * k)) c100 = c100 + 2'd1;
    end
    doy6_d = cdmc_pkg::DOY_W'(doe5_q
                              - DW'(DW'(yoe5_q) * DW'(cdmc_pkg::DAYS_NOLEAP))
                              - DW'(yoe5_q >> 2)
                              + DW'(c100));
  end

  // stage 7: March-based month, then back to January-based
  always_comb begin
    mp_num  = cdmc_pkg::MP_NUM_W'(doy6_q) * cdmc_pkg::MP_NUM_W'(5)
              + cdmc_pkg::MP_NUM_W'(2);
    mp_prod = P153_W'(mp_num) * P153_W'(cdmc_pkg::M_153);
    mp      = mp_prod[cdmc_pkg::S_153+cdmc_pkg::MON_W-1:cdmc_pkg::S_153];
    yinc7_d = (mp >= cdmc_pkg::MON_W'(cdmc_pkg::MP_JAN));
    if (s6_q.kind != cdmc_pkg::CAL_GREG) begin
      mon7_d = mng6_q;
    end else if (yinc7_d) begin
      mon7_d = mp - cdmc_pkg::MON_W'(cdmc_pkg::MP_JAN);
    end else begin
      mon7_d = mp + cdmc_pkg::MON_W'(cdmc_pkg::MAR_MON);
    end
  end

  // stage 8: 12 * year + month, wraps at the MONTH_W-bit month field, not the output width
  always_comb begin
    if (s7_q.kind == cdmc_pkg::CAL_GREG) begin
      yr8 = MW18'(yb7_q) + MW18'(yoe7_q) + MW18'(yinc7_q) - MW18'(cdmc_pkg::YEARS_ERA);
    end else begin
      yr8 = MW18'(yb7_q);
    end
    out_d = MW18'(yr8 * MW18'(cdmc_pkg::MONTHS)) + MW18'(mon7_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
      s5_q <= '0;
      s6_q <= '0;
      s7_q <= '0;
      v8_q <= 1'b0;
    end else if (en) begin
      s4_q <= s3;
      s5_q <= s4_q;
      s6_q <= s5_q;
      s7_q <= s6_q;
      v8_q <= s7_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_q    <= t4_d;
      doe4_q  <= r3;
      yb4_q   <= yb4_d;
      mng4_q  <= mng4_d;
      doe5_q  <= doe4_q;
      yoe5_q  <= yoe5_d;
      yb5_q   <= yb4_q;
      mng5_q  <= mng4_q;
      doy6_q  <= doy6_d;
      yoe6_q  <= yoe5_q;
      yb6_q   <= yb5_q;
      mng6_q  <= mng5_q;
      mon7_q  <= mon7_d;
      yinc7_q <= yinc7_d;
      yoe7_q  <= yoe6_q;
      yb7_q   <= yb6_q;
      out_q   <= out_d;
    end
  end

  assign m_axis_tvalid = v8_q;
  assign m_axis_tdata  = {(cdmc_pkg::OUT_TW - MW18)'(0), out_q};

endmodule

>>> design/cdmc_chk.sv
// Port-level checker for the day-to-month-count core, bound to the top level.
module cdmc_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [cdmc_pkg::OUT_TW-1:0] m_axis_tdata
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // input side stalls only behind a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_stall_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline frozen");

  // month count fits its field, pad bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[cdmc_pkg::OUT_TW-1:cdmc_pkg::MONTH_W] == '0)
    else $error("nonzero pad bits in output word");

endmodule

bind calendar_days_to_month_count_core cdmc_chk u_cdmc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
